FILE: rtl/hsa_pkg.sv
// ============================================================================
// hsa_pkg
// Shared types and constants of the handle slot allocator: request and result
// payloads, operation codes and the free stack command group.
// ============================================================================
package hsa_pkg;

    // Default table capacity
    localparam int unsigned SLOTS_DEF = 1024;

    // ID layout: node number above a 20-bit slot field
    localparam int unsigned ID_LOW_W = 20;
    localparam int unsigned NODE_W   = 11;

    // Operation codes
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_DEREGISTER = 2'd1;
    localparam logic [1:0] OP_LOOKUP     = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] service_id;
        logic [31:0] object_ref;
    } t_request;

    // Result payload
    typedef struct packed {
        logic        ok;
        logic [31:0] new_id;
        logic [31:0] found_ref;
    } t_result;

    // Free stack commands for one request
    typedef struct packed {
        logic pop;
        logic push;
    } t_stack_cmd;

endpackage

FILE: rtl/hsa_free_stack.sv
// ============================================================================
// hsa_free_stack
// LIFO of free slot indices held in a synchronous memory. A low-water mark on
// the fill count stands in for the reset image of the memory: entries below
// the mark were never written and read as their reset value.
// ============================================================================
module hsa_free_stack #(
    parameter int unsigned SLOTS = hsa_pkg::SLOTS_DEF,
    localparam int unsigned AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int unsigned CW   = $clog2(SLOTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsa_pkg::t_stack_cmd i_cmd,
    input  logic [AW-1:0]      i_push_slot,
    output logic [AW-1:0]      o_pop_slot,
    output logic               o_empty,
    output logic               o_full,
    output logic [CW-1:0]      o_alloc_limit
);
    import hsa_pkg::*;

    logic [AW-1:0] r_stack [SLOTS];
    logic [AW-1:0] r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_mark;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_mark;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] fresh_slot;
    logic          pristine;

    assign cnt_m1     = r_count - CW'(1);
    assign fresh_slot = CW'(SLOTS) - r_count;
    assign pristine   = (r_count == r_mark);

    // Top of stack: untouched entries hold SLOTS-1-index
    assign o_pop_slot    = pristine ? fresh_slot[AW-1:0] : r_rd_data;
    assign o_empty       = (r_count == '0);
    assign o_full        = (r_count == CW'(SLOTS));
    // Slots below this limit have been handed out at least once
    assign o_alloc_limit = CW'(SLOTS) - r_mark;

    // Memory: read top of stack every cycle, write on push
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_stack[cnt_m1[AW-1:0]];
        if (i_cmd.push) begin
            r_stack[r_count[AW-1:0]] <= i_push_slot;
        end
    end

    // Fill count and low-water mark
    always_comb begin
        n_count = r_count;
        n_mark  = r_mark;
        if (i_cmd.pop) begin
            n_count = cnt_m1;
            if (pristine) begin
                n_mark = cnt_m1;
            end
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(SLOTS);
            r_mark  <= CW'(SLOTS);
        end else begin
            r_count <= n_count;
            r_mark  <= n_mark;
        end
    end

endmodule

FILE: rtl/handle_slot_allocator.sv
// ============================================================================
// handle_slot_allocator
// Handle table with a LIFO free-slot stack: register, deregister and lookup
// of object references by ID.
// ============================================================================
// Usage:
//   Request channel: a request is taken at a clock edge where start is high
//   and busy is low. i_request carries operation, service_id and object_ref.
//   Result channel: o_done is high for exactly one cycle with o_result valid
//   in that cycle; the receiver takes it then and cannot stall it.
//   Configuration: i_cfg_we writes i_cfg_wdata into the node number; write
//   it only while no request is in flight.
// Timing:
//   A request is taken at edge A, the slot table and the free stack are read
//   on that edge, the update and the result register load on the edge that
//   ends the execute state, and o_done is high in the cycle after it. busy is
//   high for one cycle after each accepted request, so no request is taken
//   while one executes; the read-then-write of the slot memories needs this.
// Reset:
//   Synchronous, active low. All slots are free and unused, node number 0.
//   No clearing pass is needed: the fill count's low-water mark tracks which
//   slots and stack entries have ever been written.
// ============================================================================
module handle_slot_allocator #(
    parameter int unsigned SLOTS = hsa_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  hsa_pkg::t_request i_request,
    output logic              o_done,
    output hsa_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [hsa_pkg::NODE_W-1:0] i_cfg_wdata
);
    import hsa_pkg::*;

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned LW = ID_LOW_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 r_state;
    logic                 n_state;
    t_request             r_req;
    logic [NODE_W-1:0]    r_node;
    logic                 r_done;
    t_result              r_result;
    t_result              n_result;

    // Slot table entry: used flag over the stored reference
    logic [32:0]          r_table [SLOTS];
    logic [32:0]          r_tbl_rd;
    logic                 tbl_we;
    logic [AW-1:0]        tbl_waddr;
    logic [32:0]          tbl_wdata;

    logic [ID_LOW_W-1:0]  in_low_m1;
    logic [ID_LOW_W-1:0]  low;
    logic [ID_LOW_W-1:0]  low_m1;
    logic [31:0]          sid;
    logic                 id_ok;
    logic                 exec;

    t_stack_cmd           stk_cmd;
    logic [AW-1:0]        pop_slot;
    logic                 stk_empty;
    logic                 stk_full;
    logic [CW-1:0]        alloc_limit;

    hsa_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (stk_cmd),
        .i_push_slot   (low_m1[AW-1:0]),
        .o_pop_slot    (pop_slot),
        .o_empty       (stk_empty),
        .o_full        (stk_full),
        .o_alloc_limit (alloc_limit)
    );

    assign busy = (r_state == ST_EXEC);
    assign exec = (r_state == ST_EXEC);

    // Slot table read at accept, write during execute
    assign in_low_m1 = i_request.service_id[ID_LOW_W-1:0] - ID_LOW_W'(1);

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_tbl_rd <= r_table[in_low_m1[AW-1:0]];
        end
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
    end

    // ID check against the current node number
    assign sid    = r_req.service_id;
    assign low    = sid[ID_LOW_W-1:0];
    assign low_m1 = low - ID_LOW_W'(1);

    assign id_ok = (sid != '0)
                && ((sid[ID_LOW_W +: NODE_W] & r_node) != '0)
                && (low != '0)
                && ({1'b0, low} <= LW'(SLOTS))
                && r_tbl_rd[32]
                && ({1'b0, low_m1} < LW'(alloc_limit))
                && (sid[31:ID_LOW_W] == {1'b0, r_node});

    // Execute: update stack and table, form the result
    always_comb begin
        stk_cmd   = '0;
        tbl_we    = 1'b0;
        tbl_waddr = pop_slot;
        tbl_wdata = {1'b1, r_req.object_ref};
        n_result  = '0;
        if (exec) begin
            case (r_req.operation)
                OP_REGISTER: begin
                    if (!stk_empty) begin
                        stk_cmd.pop     = 1'b1;
                        tbl_we          = 1'b1;
                        n_result.ok     = 1'b1;
                        n_result.new_id = {1'b0, r_node,
                                           ID_LOW_W'({1'b0, pop_slot} + (AW + 1)'(1))};
                    end
                end
                OP_DEREGISTER: begin
                    if (id_ok && !stk_full) begin
                        stk_cmd.push = 1'b1;
                        tbl_we       = 1'b1;
                        tbl_waddr    = low_m1[AW-1:0];
                        tbl_wdata    = {1'b0, r_req.object_ref};
                        n_result.ok  = 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    if (id_ok) begin
                        n_result.ok        = 1'b1;
                        n_result.found_ref = r_tbl_rd[31:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control FSM
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_node  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= exec;
            if (i_cfg_we) begin
                r_node <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_request;
        end
        if (exec) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
